@@ rtl/core/lztd_pkg.sv @@
// Package for the LZ77 triple decompressor: sizes, controller states, command and status types.
`timescale 1ns / 1ps
`default_nettype none
package lztd_pkg;

   localparam int MAX_WINDOW = 4096;
   localparam int MAX_RUN    = 64;
   localparam int ADDR_W     = $clog2(MAX_WINDOW);
   localparam int SIZE_W     = ADDR_W + 1;
   localparam int SYM_W      = 4;
   localparam int POS_W      = 12;
   localparam int COUNT_W    = 6;
   localparam int LOG2_W     = 4;
   localparam int LOG2_MIN   = 7;
   localparam int LOG2_MAX   = ADDR_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_INIT,
      ST_ERR,
      ST_COPY,
      ST_LIT
   } state_type;

   typedef struct packed {
      logic accept;      // input channel ready
      logic start_copy;  // first window read, load run counters
      logic emit_copy;   // copied symbol to output, push into window
      logic emit_lit;    // literal to output, push into window
      logic emit_err;    // refused item
      logic emit_init;   // fill window, emit initial symbol
   } cmd_type;

   typedef struct packed {
      logic req_fire;
      logic kind;
      logic refuse;
      logic count_zero;
      logic remain_one;
      logic out_free;
   } status_type;

   // window size in symbols for a raw log2 register value
   function automatic logic [SIZE_W-1:0] window_size(input logic [LOG2_W-1:0] log2_raw);
      logic [LOG2_W-1:0] l;
      l = log2_raw;
      if (l < LOG2_W'(LOG2_MIN)) l = LOG2_W'(LOG2_MIN);
      if (l > LOG2_W'(LOG2_MAX)) l = LOG2_W'(LOG2_MAX);
      return SIZE_W'(1) << l;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/lztd_req_if.sv @@
// Input channel: one LZ77 item per word.
`timescale 1ns / 1ps
`default_nettype none
interface lztd_req_if import lztd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [POS_W-1:0]   position;
   logic [COUNT_W-1:0] count;
   logic [SYM_W-1:0]   symbol;

   modport source (output valid, kind, position, count, symbol, input ready);
   modport sink   (input valid, kind, position, count, symbol, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lztd_rsp_if.sv @@
// Result channel: one decoded symbol per word.
`timescale 1ns / 1ps
`default_nettype none
interface lztd_rsp_if import lztd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol_res;
   logic             last;
   logic             error;

   modport source (output valid, symbol_res, last, error, input ready);
   modport sink   (input valid, symbol_res, last, error, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lztd_csr_if.sv @@
// Configuration write channel: window_log2 register.
`timescale 1ns / 1ps
`default_nettype none
interface lztd_csr_if import lztd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LOG2_W-1:0] window_log2;

   modport source (output valid, window_log2, input ready);
   modport sink   (input valid, window_log2, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lztd_ctrl.sv @@
// Controller state machine for the LZ77 triple decompressor.
`timescale 1ns / 1ps
`default_nettype none
module lztd_ctrl import lztd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = 1'b1;
            if (status.req_fire) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!status.kind) begin
               state_in = ST_INIT;
            end else if (status.refuse) begin
               state_in = ST_ERR;
            end else if (status.count_zero) begin
               state_in = ST_LIT;
            end else begin
               cmd.start_copy = 1'b1;
               state_in       = ST_COPY;
            end
         end
         ST_INIT: begin
            if (status.out_free) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (status.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_COPY: begin
            if (status.out_free) begin
               cmd.emit_copy = 1'b1;
               if (status.remain_one) state_in = ST_LIT;
            end
         end
         ST_LIT: begin
            if (status.out_free) begin
               cmd.emit_lit = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/core/lztd_dp.sv @@
// Datapath: item registers, window memory with fill tracking, run counters, output register.
`timescale 1ns / 1ps
`default_nettype none
module lztd_dp import lztd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   lztd_req_if.sink      req_if,
   lztd_rsp_if.source    rsp_if,
   lztd_csr_if.sink      csr_if,
   input  wire cmd_type  cmd,
   output status_type    status
);

   // item registers
   logic               kind_ff;
   logic [POS_W-1:0]   position_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [SYM_W-1:0]   symbol_ff;

   logic [LOG2_W-1:0]  window_log2_ff;
   logic               started_ff;
   logic [ADDR_W-1:0]  oldest_ff, oldest_in;
   logic [SIZE_W-1:0]  pushed_ff, pushed_in;   // symbols pushed since fill, saturates at size
   logic [SYM_W-1:0]   fill_sym_ff;

   logic [SYM_W-1:0]   win_mem [MAX_WINDOW];
   logic [ADDR_W-1:0]  rd_addr_ff;
   logic [SYM_W-1:0]   rd_data_ff;
   logic               rd_fill_ff;
   logic [COUNT_W-1:0] remain_ff;

   logic               rsp_valid_ff;
   logic [SYM_W-1:0]   rsp_sym_ff;
   logic               rsp_last_ff;
   logic               rsp_err_ff;

   logic [SIZE_W-1:0]  size;
   logic [ADDR_W-1:0]  mask;
   logic               req_fire, csr_fire, out_free;
   logic [SIZE_W-1:0]  span;
   logic [COUNT_W:0]   run_len;
   logic [SIZE_W-1:0]  start_sum;
   logic               rd_en, wr_en, push;
   logic [ADDR_W-1:0]  rd_addr, rd_addr_next;
   logic [SYM_W-1:0]   wr_data, copy_sym;
   logic               rd_fill;

   assign size     = window_size(window_log2_ff);
   assign mask     = ADDR_W'(size - SIZE_W'(1));
   assign req_fire = req_if.valid & cmd.accept;
   assign csr_fire = csr_if.valid;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready = cmd.accept;
   assign csr_if.ready = 1'b1;

   assign span      = {1'b0, position_ff} + SIZE_W'(count_ff);
   assign run_len   = {1'b0, count_ff} + (COUNT_W+1)'(1);
   assign start_sum = {1'b0, oldest_ff} + {1'b0, position_ff};

   assign status.req_fire   = req_fire;
   assign status.kind       = kind_ff;
   assign status.refuse     = !started_ff || (span > size)
                              || (32'(run_len) > 32'(MAX_RUN));
   assign status.count_zero = (count_ff == '0);
   assign status.remain_one = (remain_ff == COUNT_W'(1));
   assign status.out_free   = out_free;

   assign copy_sym = rd_fill_ff ? fill_sym_ff : rd_data_ff;

   // window reads: first at run start, next one along with each copied word but the last
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = rd_addr_ff;
      if (cmd.start_copy) begin
         rd_en   = 1'b1;
         rd_addr = start_sum[ADDR_W-1:0] & mask;
      end else if (cmd.emit_copy && !status.remain_one) begin
         rd_en = 1'b1;
      end
   end
   assign rd_addr_next = (rd_addr + ADDR_W'(1)) & mask;
   // entry not yet overwritten since the last fill still holds the fill symbol
   assign rd_fill = (pushed_ff < size) && ({1'b0, rd_addr} >= pushed_ff);

   assign push    = cmd.emit_copy | cmd.emit_lit;
   assign wr_en   = push;
   assign wr_data = cmd.emit_copy ? copy_sym : symbol_ff;

   always_comb begin
      oldest_in = oldest_ff;
      pushed_in = pushed_ff;
      if (cmd.emit_init) begin
         oldest_in = '0;
         pushed_in = '0;
      end else if (push) begin
         oldest_in = (oldest_ff + ADDR_W'(1)) & mask;
         if (pushed_ff < size) pushed_in = pushed_ff + SIZE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) win_mem[oldest_ff] <= wr_data;
      if (rd_en) begin
         rd_data_ff <= win_mem[rd_addr];
         rd_fill_ff <= rd_fill;
         rd_addr_ff <= rd_addr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff     <= req_if.kind;
         position_ff <= req_if.position;
         count_ff    <= req_if.count;
         symbol_ff   <= req_if.symbol;
      end
      if (cmd.emit_init) fill_sym_ff <= symbol_ff;
      pushed_ff <= pushed_in;
      if (cmd.start_copy) begin
         remain_ff <= count_ff;
      end else if (cmd.emit_copy) begin
         remain_ff <= remain_ff - COUNT_W'(1);
      end
      if (cmd.emit_init || cmd.emit_lit) begin
         rsp_sym_ff  <= symbol_ff;
         rsp_last_ff <= 1'b1;
         rsp_err_ff  <= 1'b0;
      end else if (cmd.emit_copy) begin
         rsp_sym_ff  <= copy_sym;
         rsp_last_ff <= 1'b0;
         rsp_err_ff  <= 1'b0;
      end else if (cmd.emit_err) begin
         rsp_sym_ff  <= '0;
         rsp_last_ff <= 1'b1;
         rsp_err_ff  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_log2_ff <= LOG2_W'(LOG2_MIN);
         started_ff     <= 1'b0;
         oldest_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_fire) begin
            window_log2_ff <= csr_if.window_log2;
            started_ff     <= 1'b0;
         end else if (cmd.emit_init) begin
            started_ff <= 1'b1;
         end
         oldest_ff <= oldest_in;
         if (cmd.emit_init || cmd.emit_lit || cmd.emit_copy || cmd.emit_err) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.symbol_res = rsp_sym_ff;
   assign rsp_if.last       = rsp_last_ff;
   assign rsp_if.error      = rsp_err_ff;

endmodule
`default_nettype wire

@@ rtl/core/lz77_triple_decompressor_unit.sv @@
// LZ77 triple decompressor over 4-bit symbols: top level.
//
// req_if takes one LZ77 item per word: an initial item (kind 0) that fills the
// whole window with its symbol, or a triple (position, count, symbol) that
// copies count symbols out of the window and then emits the literal.
// rsp_if gives one decoded symbol per word; last marks the final word of an
// item, error marks a refused triple (no initial item yet, or a copy that runs
// past the window), whose single word carries symbol 0.
// csr_if writes window_log2 (clamped to 7..12); a write drops the started
// state, so an initial item must come before the next triple.
// Timing: after an item is taken the controller passes DECIDE, then loads the first word
// into the output register from INIT, ERR, COPY or LIT; then one word per cycle while
// the receiver takes them. The single read port of the window memory sets the
// one-symbol-per-cycle pace. One item is worked at a time; the next is taken
// the cycle after the last word of the previous one is loaded.
// The initial fill writes no window entries: unwritten entries read as the fill symbol.
// Reset (synchronous) clears the controller, the output register and started.
// A stalled receiver holds the output word; the run pauses until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module lz77_triple_decompressor_unit import lztd_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   lztd_req_if.sink   req_if,
   lztd_rsp_if.source rsp_if,
   lztd_csr_if.sink   csr_if
);

   cmd_type    cmd;
   status_type status;

   lztd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   lztd_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if),
      .cmd    (cmd),
      .status (status)
   );

endmodule
`default_nettype wire

@@ rtl/core/lztd_checker.sv @@
// Port-level assertions for the LZ77 triple decompressor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lztd_checker import lztd_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [SYM_W-1:0] rsp_symbol_res,
   input wire logic             rsp_last,
   input wire logic             rsp_error
);

   // a refused item gives a single zero word
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && (rsp_symbol_res == '0))
      else $error("error word not final or not zero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol_res)
                                  && $stable(rsp_last) && $stable(rsp_error))
      else $error("stalled result word changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while previous one in work");

endmodule

bind lz77_triple_decompressor_unit lztd_checker u_lztd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_symbol_res (rsp_if.symbol_res),
   .rsp_last       (rsp_if.last),
   .rsp_error      (rsp_if.error)
);
`default_nettype wire

@@ bench/lz77_triple_decompressor_unit_test.sv @@
// Self-checking bench for the LZ77 triple decompressor: directed table, then random phases.
`timescale 1ns / 1ps
module lz77_triple_decompressor_unit_test;
   import lztd_pkg::*;

   localparam bit KIND_INIT   = 1'b0;
   localparam bit KIND_TRIPLE = 1'b1;

   localparam int RAW_LOG2_LO  = 7;
   localparam int RAW_LOG2_HI  = 12;
   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 8;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS  = 50;

   typedef struct packed {
      logic               kind;
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] count;
      logic [SYM_W-1:0]   symbol;
   } lz_item_t;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
      logic             error;
   } sym_word_t;

   typedef struct packed {
      logic               kind;
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] count;
      logic [SYM_W-1:0]   symbol;
      logic               typed;
      logic [SYM_W-1:0]   w_symbol;
      logic               w_last;
      logic               w_error;
   } dir_row_t;

   // window is 128 symbols here (register at its reset value)
   localparam int N_DIRECTED = 17;
   localparam dir_row_t DIRECTED [N_DIRECTED] = '{
      '{KIND_TRIPLE, 12'd0,    6'd0,  4'd5,  1'b1, 4'd0,  1'b1, 1'b1}, // no initial item yet
      '{KIND_TRIPLE, 12'd4095, 6'd63, 4'd15, 1'b1, 4'd0,  1'b1, 1'b1},
      '{KIND_INIT,   12'd0,    6'd0,  4'd15, 1'b1, 4'd15, 1'b1, 1'b0},
      '{KIND_TRIPLE, 12'd0,    6'd0,  4'd0,  1'b1, 4'd0,  1'b1, 1'b0}, // literal only
      '{KIND_TRIPLE, 12'd127,  6'd1,  4'd3,  1'b0, 4'd0,  1'b0, 1'b0},
      '{KIND_TRIPLE, 12'd127,  6'd2,  4'd3,  1'b1, 4'd0,  1'b1, 1'b1}, // runs past window
      '{KIND_TRIPLE, 12'd4095, 6'd0,  4'd1,  1'b1, 4'd0,  1'b1, 1'b1},
      '{KIND_TRIPLE, 12'd0,    6'd63, 4'd2,  1'b0, 4'd0,  1'b0, 1'b0}, // longest run
      '{KIND_TRIPLE, 12'd0,    6'd62, 4'd10, 1'b0, 4'd0,  1'b0, 1'b0},
      '{KIND_TRIPLE, 12'd66,   6'd62, 4'd5,  1'b0, 4'd0,  1'b0, 1'b0}, // ends at window edge
      '{KIND_TRIPLE, 12'd1,    6'd20, 4'd12, 1'b0, 4'd0,  1'b0, 1'b0},
      '{KIND_INIT,   12'd4095, 6'd63, 4'd0,  1'b1, 4'd0,  1'b1, 1'b0}, // refill, fields ignored
      '{KIND_TRIPLE, 12'd100,  6'd28, 4'd7,  1'b0, 4'd0,  1'b0, 1'b0},
      '{KIND_TRIPLE, 12'd0,    6'd1,  4'd15, 1'b0, 4'd0,  1'b0, 1'b0},
      '{KIND_INIT,   12'd2730, 6'd42, 4'd10, 1'b1, 4'd10, 1'b1, 1'b0},
      '{KIND_TRIPLE, 12'd1365, 6'd21, 4'd5,  1'b1, 4'd0,  1'b1, 1'b1},
      '{KIND_TRIPLE, 12'd5,    6'd21, 4'd9,  1'b0, 4'd0,  1'b0, 1'b0}
   };

   logic clock;
   logic reset;

   lztd_req_if req_bus ();
   lztd_rsp_if rsp_bus ();
   lztd_csr_if csr_bus ();

   lz77_triple_decompressor_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // shadow decoder state
   logic [SYM_W-1:0]  win_mem [MAX_WINDOW];
   int unsigned       oldest_pos;
   bit                has_started;
   logic [LOG2_W-1:0] log2_reg;

   sym_word_t pending_words [$];
   sym_word_t step_words [$];

   int  failures;
   int  words_seen;
   int  refused_seen;
   int  items_sent;
   int  settings_used;
   bit  no_idle;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned win_size();
      int unsigned l;
      l = log2_reg;
      if (l < RAW_LOG2_LO) l = RAW_LOG2_LO;
      if (l > RAW_LOG2_HI) l = RAW_LOG2_HI;
      return 1 << l;
   endfunction

   function automatic void slide_in(input logic [SYM_W-1:0] s, input int unsigned size);
      int unsigned o;
      o = oldest_pos % size;
      win_mem[o] = s;
      o++;
      if (o >= size) o = 0;
      oldest_pos = o;
   endfunction

   // words one item yields; also advances the shadow window
   function automatic void decode_item(input lz_item_t it);
      int unsigned size;
      int unsigned i;
      logic [SYM_W-1:0] run [MAX_RUN];
      size = win_size();
      step_words.delete();
      if (it.kind == KIND_INIT) begin
         for (i = 0; i < size; i++) win_mem[i] = it.symbol;
         oldest_pos  = 0;
         has_started = 1'b1;
         step_words.insert(step_words.size(), sym_word_t'{it.symbol, 1'b1, 1'b0});
      end else if (!has_started || int'(it.position) + int'(it.count) > int'(size)
                   || int'(it.count) + 1 > MAX_RUN) begin
         step_words.insert(step_words.size(), sym_word_t'{4'd0, 1'b1, 1'b1});
      end else begin
         // copies all come from the window as it was before this triple
         for (i = 0; i < it.count; i++)
            run[i] = win_mem[(oldest_pos + it.position + i) % size];
         for (i = 0; i < it.count; i++) begin
            step_words.insert(step_words.size(), sym_word_t'{run[i], 1'b0, 1'b0});
            slide_in(run[i], size);
         end
         step_words.insert(step_words.size(), sym_word_t'{it.symbol, 1'b1, 1'b0});
         slide_in(it.symbol, size);
      end
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void check_word(input sym_word_t got);
      sym_word_t want;
      words_seen++;
      if (got.error) refused_seen++;
      if (pending_words.size() == 0) begin
         failures++;
         $display("%0t: word with nothing expected: symbol %h last %b error %b",
                  $time, got.symbol, got.last, got.error);
         return;
      end
      want = pending_words[0];
      pending_words.delete(0);
      if (got.symbol !== want.symbol) begin
         failures++;
         $display("%0t: symbol_res expected %h got %h", $time, want.symbol, got.symbol);
      end
      if (got.last !== want.last) begin
         failures++;
         $display("%0t: last expected %b got %b", $time, want.last, got.last);
      end
      if (got.error !== want.error) begin
         failures++;
         $display("%0t: error expected %b got %b", $time, want.error, got.error);
      end
   endfunction

   // offer one item, predict on acceptance, then maybe idle
   task automatic send_req(input lz_item_t it, input bit typed, input sym_word_t typed_word);
      int gap;
      req_bus.valid    <= 1'b1;
      req_bus.kind     <= it.kind;
      req_bus.position <= it.position;
      req_bus.count    <= it.count;
      req_bus.symbol   <= it.symbol;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      items_sent++;
      decode_item(it);
      if (typed) pending_words.insert(pending_words.size(), typed_word);
      else foreach (step_words[i]) pending_words.insert(pending_words.size(), step_words[i]);
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_window_log2(input logic [LOG2_W-1:0] v);
      req_bus.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_bus.valid       <= 1'b1;
      csr_bus.window_log2 <= v;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      log2_reg    = v;
      has_started = 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(input int n_items);
      lz_item_t    it;
      int unsigned size;
      int unsigned r;
      int unsigned cnt;
      int          k;
      size = win_size();
      // started was just cleared: this triple must be refused
      it.kind     = KIND_TRIPLE;
      it.count    = COUNT_W'($urandom_range(0, 8));
      it.position = POS_W'($urandom_range(0, size - it.count));
      it.symbol   = SYM_W'($urandom);
      send_req(it, 1'b0, '0);
      it.kind     = KIND_INIT;
      it.position = POS_W'($urandom);
      it.count    = COUNT_W'($urandom);
      it.symbol   = SYM_W'($urandom);
      send_req(it, 1'b0, '0);
      for (k = 0; k < n_items; k++) begin
         r         = $urandom_range(0, 99);
         it.symbol = SYM_W'($urandom);
         if (r < 5) begin
            it.kind     = KIND_INIT;
            it.position = POS_W'($urandom);
            it.count    = COUNT_W'($urandom);
         end else if (r < 15) begin
            it.kind     = KIND_TRIPLE;
            it.position = POS_W'($urandom);
            it.count    = COUNT_W'($urandom);
         end else if (r < 20) begin
            // just past the window end
            it.kind     = KIND_TRIPLE;
            cnt         = $urandom_range(2, MAX_RUN - 2);
            it.count    = COUNT_W'(cnt);
            it.position = POS_W'(size - cnt + $urandom_range(1, cnt - 1));
         end else begin
            it.kind  = KIND_TRIPLE;
            cnt      = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 8)
                                                   : $urandom_range(9, MAX_RUN - 2);
            it.count    = COUNT_W'(cnt);
            it.position = POS_W'($urandom_range(0, size - cnt));
         end
         send_req(it, 1'b0, '0);
      end
   endtask

   // result side: random stalls, one long hold-off
   initial begin : rsp_side
      int gap;
      bit held;
      held = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (words_seen == HOLD_AT && !held) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         check_word('{rsp_bus.symbol_res, rsp_bus.last, rsp_bus.error});
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
            idle = 0;
         else
            idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL lz77_triple_decompressor_unit");
            $finish;
         end
      end
   end

   initial begin : req_side
      lz_item_t          it;
      sym_word_t         w;
      logic [LOG2_W-1:0] settings [7];
      int                p;
      failures      = 0;
      words_seen    = 0;
      refused_seen  = 0;
      items_sent    = 0;
      settings_used = 1;
      no_idle       = 1'b0;
      oldest_pos    = 0;
      has_started   = 1'b0;
      log2_reg      = LOG2_W'(RAW_LOG2_LO);
      settings = '{4'd12, 4'd0, 4'd15, 4'd9, LOG2_W'($urandom_range(0, 15)), 4'd10, 4'd7};
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= KIND_INIT;
      req_bus.position    <= '0;
      req_bus.count       <= '0;
      req_bus.symbol      <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.window_log2 <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         it = '{DIRECTED[i].kind, DIRECTED[i].position, DIRECTED[i].count, DIRECTED[i].symbol};
         w  = '{DIRECTED[i].w_symbol, DIRECTED[i].w_last, DIRECTED[i].w_error};
         send_req(it, DIRECTED[i].typed, w);
      end

      for (p = 0; p < 7; p++) begin
         write_window_log2(settings[p]);
         no_idle = p[0];
         run_phase(PHASE_ITEMS);
      end

      req_bus.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run: %0d items over %0d window settings, %0d words checked, %0d refused",
               items_sent, settings_used, words_seen, refused_seen);
      if (failures == 0) begin
         $display("PASS lz77_triple_decompressor_unit");
      end else begin
         $display("%0d mismatches", failures);
         $display("FAIL lz77_triple_decompressor_unit");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/lztd_pkg.sv
rtl/core/lztd_req_if.sv
rtl/core/lztd_rsp_if.sv
rtl/core/lztd_csr_if.sv
rtl/core/lztd_ctrl.sv
rtl/core/lztd_dp.sv
rtl/core/lz77_triple_decompressor_unit.sv
rtl/core/lztd_checker.sv
bench/lz77_triple_decompressor_unit_test.sv
